// File: rtl/uefd_pkg.sv
// ----------------------------------------------------------------------------
// uefd_pkg: shared definitions for the utf8 emoji flood detector
// Field widths, decoder codes, emoji range tables, register indexes,
// verdict codes and the state type of the seen-map scrubber.
// ----------------------------------------------------------------------------
`default_nettype none

package uefd_pkg;

   // default sizing of the top level
   localparam int SEEN_ENTRIES_DEF = 4096;
   localparam int COUNT_WIDTH_DEF  = 16;
   // epoch tag bits beyond the seen-map address width
   localparam int TAG_GUARD_BITS   = 4;
   localparam int TAG_W_DEF        = 16;

   // field widths
   localparam int TEXT_W      = 8;
   localparam int TOTAL_W     = 16;
   localparam int UNIQUE_W    = 12;
   localparam int KIND_W      = 2;
   localparam int HIT_W       = 16;
   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   // code point and dense index widths
   localparam int CP_W    = 21;
   localparam int DENSE_W = 12;

   // result buffer
   localparam int OUT_DEPTH = 4;
   localparam int OUT_PTR_W = 2;
   localparam int OUT_CNT_W = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_TOTAL  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_UNIQUE = 1'b1;

   // utf-8 lead byte prefixes and payload mask
   localparam logic [2:0] LEAD2_TAG = 3'b110;
   localparam logic [3:0] LEAD3_TAG = 4'b1110;
   localparam logic [4:0] LEAD4_TAG = 5'b11110;
   localparam int         CONT_BITS = 6;

   // emoji ranges, inclusive, with the dense index of each range start
   localparam int RANGE_COUNT = 10;
   localparam logic [CP_W-1:0] RANGE_LO [RANGE_COUNT] = '{
      21'h1F000, 21'h1F0A0, 21'h1F100, 21'h1F300, 21'h1F680,
      21'h02300, 21'h02600, 21'h0FE00, 21'h02B50, 21'h02B55
   };
   localparam logic [CP_W-1:0] RANGE_HI [RANGE_COUNT] = '{
      21'h1F02F, 21'h1F0FF, 21'h1F2FF, 21'h1F64F, 21'h1FAFF,
      21'h023FF, 21'h027BF, 21'h0FE0F, 21'h02B50, 21'h02B55
   };
   localparam logic [DENSE_W-1:0] RANGE_BASE [RANGE_COUNT] = '{
      12'd0, 12'd48, 12'd144, 12'd656, 12'd1504,
      12'd2656, 12'd2912, 12'd3360, 12'd3376, 12'd3377
   };
   // zero width joiner sits after all ranges
   localparam logic [CP_W-1:0]    ZWJ_POINT = 21'h0200D;
   localparam logic [DENSE_W-1:0] ZWJ_INDEX = 12'd3378;

   // verdict codes
   typedef enum logic [KIND_W-1:0] {
      LIMIT_NONE   = 2'd0,
      LIMIT_TOTAL  = 2'd1,
      LIMIT_UNIQUE = 2'd2
   } limit_kind_type;

   // seen-map scrubber states
   typedef enum logic [1:0] {
      SCRUB_INIT,
      SCRUB_READ,
      SCRUB_CHECK
   } scrub_state_type;

   typedef struct packed {
      logic                  hit;
      logic [DENSE_W-1:0]    idx;
   } emoji_class_type;

   typedef struct packed {
      logic [TOTAL_W-1:0]    total;
      logic [UNIQUE_W-1:0]   uniq;
      logic                  attack;
      limit_kind_type        kind;
      logic [HIT_W-1:0]      hit;
   } result_type;

   // range test and dense index of one code point
   function automatic emoji_class_type emoji_classify(input logic [CP_W-1:0] cp);
      emoji_class_type res;
      res.hit = 1'b0;
      res.idx = '0;
      for (int r = 0; r < RANGE_COUNT; r++) begin
         if (cp >= RANGE_LO[r] && cp <= RANGE_HI[r]) begin
            res.hit = 1'b1;
            res.idx = RANGE_BASE[r] + DENSE_W'(cp - RANGE_LO[r]);
         end
      end
      if (cp == ZWJ_POINT) begin
         res.hit = 1'b1;
         res.idx = ZWJ_INDEX;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

// File: rtl/uefd_req_if.sv
// ----------------------------------------------------------------------------
// uefd_req_if: byte input channel
// Valid/ready channel carrying one message byte and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface uefd_req_if;
   logic                        valid;
   logic                        ready;
   logic [uefd_pkg::TEXT_W-1:0] text_byte;
   logic                        last_byte;

   modport source (output valid, output text_byte, output last_byte, input ready);
   modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// File: rtl/uefd_rsp_if.sv
// ----------------------------------------------------------------------------
// uefd_rsp_if: message result channel
// Valid/ready channel carrying the per-message counts and verdict.
// ----------------------------------------------------------------------------
`default_nettype none

interface uefd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [uefd_pkg::TOTAL_W-1:0]  total_emoji;
   logic [uefd_pkg::UNIQUE_W-1:0] unique_emoji;
   logic                          is_attack;
   logic [uefd_pkg::KIND_W-1:0]   limit_kind;
   logic [uefd_pkg::HIT_W-1:0]    limit_hit;

   modport source (output valid, output total_emoji, output unique_emoji,
                   output is_attack, output limit_kind, output limit_hit,
                   input ready);
   modport sink   (input valid, input total_emoji, input unique_emoji,
                   input is_attack, input limit_kind, input limit_hit,
                   output ready);
endinterface

`default_nettype wire

// File: rtl/utf8_emoji_flood_detector.sv
// ----------------------------------------------------------------------------
// utf8_emoji_flood_detector: per-message emoji counter and flood verdict
// Lax utf-8 decode, emoji range classification, saturating total count,
// distinct count through an epoch-tagged seen map, verdict on the last byte.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake         contents
//  req_chan  in   valid / ready     text_byte, last_byte
//  rsp_chan  out  valid / ready     total_emoji, unique_emoji, is_attack,
//                                   limit_kind, limit_hit
//  csr_*     in   csr_write only    csr_index, csr_data (max_total, max_unique)
//
//  One byte per cycle while req ready is high; the three-stage path is decode, classify
//  with seen-map read, then count update on the registered read data.
//  A message result is valid once its last byte has passed stages 1 and 2 and is in the buffer.
//  After reset the seen map is swept entry by entry with req ready
//  low; register writes are taken throughout.
//  Up to four results are buffered; req ready drops while four messages
//  have results outstanding.
//
`default_nettype none

module utf8_emoji_flood_detector #(
   parameter int SEEN_ENTRIES = uefd_pkg::SEEN_ENTRIES_DEF,
   parameter int COUNT_WIDTH  = uefd_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   uefd_req_if.sink                              req_chan,
   uefd_rsp_if.source                            rsp_chan,
   input  wire logic                             csr_write,
   input  wire logic [uefd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [uefd_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = $clog2(SEEN_ENTRIES);
   localparam int TAG_W = IDX_W + uefd_pkg::TAG_GUARD_BITS;
   localparam int CMP_W = (COUNT_WIDTH > uefd_pkg::TOTAL_W) ? COUNT_WIDTH
                                                            : uefd_pkg::TOTAL_W;
   localparam int CP_W  = uefd_pkg::CP_W;
   localparam logic [IDX_W-1:0] PTR_LAST = IDX_W'(SEEN_ENTRIES - 1);

   // configuration registers
   logic [uefd_pkg::TOTAL_W-1:0]  max_total_ff;
   logic [uefd_pkg::UNIQUE_W-1:0] max_unique_ff;

   // decoder state
   logic [1:0]      pend_ff, pend_in;
   logic [CP_W-1:0] part_ff, part_in;
   logic            dec_done;
   logic [CP_W-1:0] dec_cp;

   // pipeline registers
   logic             s1_valid_ff, s1_done_ff, s1_last_ff;
   logic [CP_W-1:0]  s1_cp_ff;
   logic             s2_valid_ff, s2_emoji_ff, s2_last_ff;
   logic [IDX_W-1:0] s2_idx_ff;
   uefd_pkg::emoji_class_type s1_class;

   // counters and epoch
   logic [COUNT_WIDTH-1:0]        total_ff, total_in, total_upd;
   logic [uefd_pkg::UNIQUE_W-1:0] distinct_ff, distinct_in, distinct_upd;
   logic [TAG_W-1:0]              epoch_ff, epoch_in, marker;

   // seen map ports
   logic             look_we, mem_we;
   logic [IDX_W-1:0] mem_waddr, look_raddr;
   logic [TAG_W-1:0] mem_wdata, look_tag, scrub_tag;
   logic             seen;

   // scrubber
   uefd_pkg::scrub_state_type scrub_state_ff, scrub_state_in;
   logic [IDX_W-1:0] scrub_ptr_ff, scrub_ptr_in;
   logic             haz_ff, haz_in;
   logic             scrub_we, scrub_adv;

   // verdict and result buffer
   logic [CMP_W-1:0]            tot_ext;
   uefd_pkg::result_type        res;
   uefd_pkg::result_type        fifo_ff [uefd_pkg::OUT_DEPTH];
   logic [uefd_pkg::OUT_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [uefd_pkg::OUT_CNT_W-1:0] fifo_cnt_ff, fifo_cnt_in;
   logic [uefd_pkg::OUT_CNT_W-1:0] reserved_ff, reserved_in;
   logic req_xfer, rsp_xfer, push, rsv_inc;

   // handshakes
   assign req_chan.ready = (scrub_state_ff != uefd_pkg::SCRUB_INIT) &&
                           (reserved_ff < uefd_pkg::OUT_CNT_W'(uefd_pkg::OUT_DEPTH));
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_total_ff  <= '0;
         max_unique_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            uefd_pkg::CSR_MAX_TOTAL:  max_total_ff  <= csr_data;
            uefd_pkg::CSR_MAX_UNIQUE: max_unique_ff <= csr_data[uefd_pkg::UNIQUE_W-1:0];
         endcase
      end
   end

   // lax utf-8 decode of the transferred byte
   always_comb begin
      pend_in  = pend_ff;
      part_in  = part_ff;
      dec_done = 1'b0;
      dec_cp   = {part_ff[CP_W-uefd_pkg::CONT_BITS-1:0],
                  req_chan.text_byte[uefd_pkg::CONT_BITS-1:0]};
      if (req_xfer) begin
         if (pend_ff != 2'd0) begin
            part_in  = dec_cp;
            pend_in  = pend_ff - 2'd1;
            dec_done = (pend_ff == 2'd1);
         end else if (!req_chan.text_byte[7]) begin
            dec_done = 1'b1;
            dec_cp   = CP_W'(req_chan.text_byte);
         end else if (req_chan.text_byte[7:5] == uefd_pkg::LEAD2_TAG) begin
            part_in = CP_W'(req_chan.text_byte[4:0]);
            pend_in = 2'd1;
         end else if (req_chan.text_byte[7:4] == uefd_pkg::LEAD3_TAG) begin
            part_in = CP_W'(req_chan.text_byte[3:0]);
            pend_in = 2'd2;
         end else if (req_chan.text_byte[7:3] == uefd_pkg::LEAD4_TAG) begin
            part_in = CP_W'(req_chan.text_byte[2:0]);
            pend_in = 2'd3;
         end
         // a sequence cut off at message end is dropped
         if (req_chan.last_byte) begin
            pend_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 2'd0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
   end

   // stage 1: completed code point
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      s1_done_ff <= dec_done;
      s1_cp_ff   <= dec_cp;
      s1_last_ff <= req_chan.last_byte;
   end

   // classify and look up the seen map
   assign s1_class   = uefd_pkg::emoji_classify(s1_cp_ff);
   assign look_raddr = IDX_W'(s1_class.idx);

   // stage 2: emoji flag and dense index
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_emoji_ff <= s1_done_ff && s1_class.hit;
      s2_idx_ff   <= look_raddr;
      s2_last_ff  <= s1_last_ff;
   end

   // count update from the seen-map tag
   assign seen    = (look_tag == epoch_ff);
   assign look_we = s2_valid_ff && s2_emoji_ff && !seen;
   assign marker  = {~epoch_ff[TAG_W-1], epoch_ff[TAG_W-2:0]};

   always_comb begin
      total_upd    = total_ff;
      distinct_upd = distinct_ff;
      if (s2_valid_ff && s2_emoji_ff) begin
         if (total_ff != '1) begin
            total_upd = total_ff + COUNT_WIDTH'(1);
         end
         if (!seen) begin
            distinct_upd = distinct_ff + uefd_pkg::UNIQUE_W'(1);
         end
      end
   end

   // verdict, total limit first
   always_comb begin
      tot_ext    = CMP_W'(total_upd);
      res.total  = tot_ext[uefd_pkg::TOTAL_W-1:0];
      res.uniq   = distinct_upd;
      res.attack = 1'b0;
      res.kind   = uefd_pkg::LIMIT_NONE;
      res.hit    = '0;
      if (max_total_ff != '0 && tot_ext > CMP_W'(max_total_ff)) begin
         res.attack = 1'b1;
         res.kind   = uefd_pkg::LIMIT_TOTAL;
         res.hit    = max_total_ff;
      end else if (max_unique_ff != '0 && distinct_upd > max_unique_ff) begin
         res.attack = 1'b1;
         res.kind   = uefd_pkg::LIMIT_UNIQUE;
         res.hit    = uefd_pkg::HIT_W'(max_unique_ff);
      end
   end

   // message end clears counts and opens a new epoch
   assign push = s2_valid_ff && s2_last_ff;

   always_comb begin
      total_in    = total_upd;
      distinct_in = distinct_upd;
      epoch_in    = epoch_ff;
      if (push) begin
         total_in    = '0;
         distinct_in = '0;
         epoch_in    = epoch_ff + TAG_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff    <= '0;
         distinct_ff <= '0;
         epoch_ff    <= '0;
      end else begin
         total_ff    <= total_in;
         distinct_ff <= distinct_in;
         epoch_ff    <= epoch_in;
      end
   end

   // scrubber next state
   always_comb begin
      scrub_state_in = scrub_state_ff;
      unique case (scrub_state_ff)
         uefd_pkg::SCRUB_INIT: begin
            if (scrub_ptr_ff == PTR_LAST) begin
               scrub_state_in = uefd_pkg::SCRUB_READ;
            end
         end
         uefd_pkg::SCRUB_READ:  scrub_state_in = uefd_pkg::SCRUB_CHECK;
         uefd_pkg::SCRUB_CHECK: scrub_state_in = uefd_pkg::SCRUB_READ;
         default:               scrub_state_in = uefd_pkg::SCRUB_INIT;
      endcase
   end

   // scrubber outputs: stale tags get a far-off marker
   always_comb begin
      scrub_we  = 1'b0;
      scrub_adv = 1'b0;
      unique case (scrub_state_ff)
         uefd_pkg::SCRUB_INIT: begin
            scrub_we  = 1'b1;
            scrub_adv = 1'b1;
         end
         uefd_pkg::SCRUB_READ: begin
            scrub_we  = 1'b0;
         end
         uefd_pkg::SCRUB_CHECK: begin
            // lookup owns the write port; retry the entry next round
            if (!look_we) begin
               scrub_adv = 1'b1;
               scrub_we  = !haz_ff && (scrub_tag != epoch_ff);
            end
         end
         default: begin
            scrub_we  = 1'b0;
         end
      endcase
   end

   assign scrub_ptr_in = !scrub_adv ? scrub_ptr_ff :
                         (scrub_ptr_ff == PTR_LAST) ? '0 : scrub_ptr_ff + IDX_W'(1);
   // entry written by a lookup while the scrubber read it
   assign haz_in = (scrub_state_ff == uefd_pkg::SCRUB_READ) && look_we &&
                   (s2_idx_ff == scrub_ptr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         scrub_state_ff <= uefd_pkg::SCRUB_INIT;
         scrub_ptr_ff   <= '0;
         haz_ff         <= 1'b0;
      end else begin
         scrub_state_ff <= scrub_state_in;
         scrub_ptr_ff   <= scrub_ptr_in;
         haz_ff         <= haz_in;
      end
   end

   // seen map write arbitration
   assign mem_we    = look_we || scrub_we;
   assign mem_waddr = look_we ? s2_idx_ff : scrub_ptr_ff;
   assign mem_wdata = look_we ? epoch_ff : marker;

   uefd_ram #(
      .WIDTH (TAG_W),
      .DEPTH (SEEN_ENTRIES)
   ) u_seen_map (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (look_raddr),
      .rd_data_a (look_tag),
      .rd_addr_b (scrub_ptr_ff),
      .rd_data_b (scrub_tag)
   );

   // result buffer and reservation count
   assign rsv_inc = req_xfer && req_chan.last_byte;

   always_comb begin
      reserved_in = reserved_ff;
      fifo_cnt_in = fifo_cnt_ff;
      if (rsv_inc && !rsp_xfer) begin
         reserved_in = reserved_ff + uefd_pkg::OUT_CNT_W'(1);
      end else if (!rsv_inc && rsp_xfer) begin
         reserved_in = reserved_ff - uefd_pkg::OUT_CNT_W'(1);
      end
      if (push && !rsp_xfer) begin
         fifo_cnt_in = fifo_cnt_ff + uefd_pkg::OUT_CNT_W'(1);
      end else if (!push && rsp_xfer) begin
         fifo_cnt_in = fifo_cnt_ff - uefd_pkg::OUT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reserved_ff <= '0;
         fifo_cnt_ff <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
      end else begin
         reserved_ff <= reserved_in;
         fifo_cnt_ff <= fifo_cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + uefd_pkg::OUT_PTR_W'(1);
         end
         if (rsp_xfer) begin
            rd_ptr_ff <= rd_ptr_ff + uefd_pkg::OUT_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= res;
      end
   end

   // result channel
   assign rsp_chan.valid        = (fifo_cnt_ff != '0);
   assign rsp_chan.total_emoji  = fifo_ff[rd_ptr_ff].total;
   assign rsp_chan.unique_emoji = fifo_ff[rd_ptr_ff].uniq;
   assign rsp_chan.is_attack    = fifo_ff[rd_ptr_ff].attack;
   assign rsp_chan.limit_kind   = fifo_ff[rd_ptr_ff].kind;
   assign rsp_chan.limit_hit    = fifo_ff[rd_ptr_ff].hit;

   // buffered results never outnumber reserved slots
   assert property (@(posedge clock) disable iff (reset)
      fifo_cnt_ff <= reserved_ff)
      else $error("result buffer holds more entries than reserved");

   // lookup and scrubber never write the seen map together
   assert property (@(posedge clock) disable iff (reset)
      !(look_we && scrub_we))
      else $error("seen map write port conflict");

   // emoji updates are spaced so the read-after-write needs no bypass
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && s2_emoji_ff) |=> !(s2_valid_ff && s2_emoji_ff))
      else $error("emoji updates in consecutive cycles");

   // counts restart after each message end
   assert property (@(posedge clock) disable iff (reset)
      push |=> (total_ff == '0 && distinct_ff == '0))
      else $error("counts not cleared at message end");

endmodule

`default_nettype wire

// File: rtl/uefd_ram.sv
// ----------------------------------------------------------------------------
// uefd_ram: generic memory, one write port, two registered read ports
// Read data shows the contents before a write at the same edge.
// ----------------------------------------------------------------------------
`default_nettype none

module uefd_ram #(
   parameter int  WIDTH = uefd_pkg::TAG_W_DEF,
   parameter int  DEPTH = uefd_pkg::SEEN_ENTRIES_DEF,
   localparam int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr_a,
   output logic      [WIDTH-1:0] rd_data_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff, rd_b_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read ports
   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire
